### rtl/core/ffha_pkg.sv
`timescale 1ns / 1ps
package ffha_pkg;
    localparam int SZ_BITS = 21;
    localparam int B_FREE = 21;
    localparam int B_PFREE = 22;
    localparam int B_END = 23;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_OOM = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    typedef struct packed {
        logic        func;
        logic [15:0] request_bytes;
        logic [15:0] block_addr;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] payload_addr;
        logic [1:0]  status;
        logic [15:0] break_offset;
    } t_out_beat;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE,
        S_A_RD, S_A_CHK, S_A_END2, S_A_SP2, S_A_SP3, S_A_NXRD, S_A_NXWR,
        S_F_RD, S_F_CHK, S_F_NXRD, S_F_NXCHK, S_F_WT, S_F_PRD, S_F_PCHK,
        S_F_TAG, S_F_ERD, S_F_ECHK
    } t_state;
endpackage

### rtl/core/ffha_if.sv
`timescale 1ns / 1ps
interface ffha_in_if import ffha_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ffha_out_if import ffha_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/first_fit_heap_allocator_top.sv
`timescale 1ns / 1ps
// Channel  Dir  Beat
// i_in     in   func, request_bytes, block_addr
// o_out    out  payload_addr, status, break_offset
// An allocate, or a free of an address not below HEADER_BYTES, walks the list from
// offset 0 block by block; each block passes a read state and a check state.
// The heap RAM is a single port pair: one read, one write per cycle.
// After reset, state S_INIT writes the end marker before the first beat is taken.
// A new beat is taken only while the result register is empty.
module first_fit_heap_allocator_top import ffha_pkg::*; #(
    parameter int HEAP_BYTES = 65536,
    parameter int HEADER_BYTES = 8,
    parameter int ALIGN_BYTES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffha_in_if.sink    i_in,
    ffha_out_if.source o_out
);
    localparam int OW = $clog2(HEAP_BYTES) + 2;
    localparam int DEPTH = HEAP_BYTES / 4;
    localparam int AW = $clog2(DEPTH);
    localparam logic [OW-1:0] HB = OW'(HEADER_BYTES);
    localparam logic [OW-1:0] AB = OW'(ALIGN_BYTES);
    localparam logic [OW-1:0] HEAP = OW'(HEAP_BYTES);

    logic [31:0] mem [0:DEPTH-1];
    logic [31:0] rdata;
    logic        we;
    logic [OW-1:0] waddr;
    logic [31:0] wdata;

    t_state r_state, n_state;
    logic [OW-1:0] r_ptr, n_ptr, r_head, n_head, r_prev, n_prev, r_nx, n_nx;
    logic [OW-1:0] r_need, n_need, r_target, n_target, r_break, n_break;
    logic [31:0] r_h, n_h;
    logic r_has_prev, n_has_prev;
    logic r_out_valid, n_out_valid;
    t_out_beat r_out, n_out;

    logic [OW-1:0] size, hsize, round;
    logic [31:0] h_merged;

    always_ff @(posedge i_clk) begin
        if (we && waddr < HEAP) begin
            mem[waddr[AW+1:2]] <= wdata;
        end
        rdata <= mem[r_ptr[AW+1:2]];
    end

    assign size = OW'(rdata[SZ_BITS-1:0]);
    assign hsize = OW'(r_h[SZ_BITS-1:0]);
    assign round = (OW'(i_in.data.request_bytes) + AB - OW'(1)) & ~(AB - OW'(1));
    assign i_in.ready = (r_state == S_IDLE) && !r_out_valid;
    assign o_out.valid = r_out_valid;
    assign o_out.data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_out_valid <= 1'b0;
            r_break <= HB;
            r_has_prev <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
            r_break <= n_break;
            r_has_prev <= n_has_prev;
        end
        r_ptr <= n_ptr;
        r_head <= n_head;
        r_prev <= n_prev;
        r_nx <= n_nx;
        r_need <= n_need;
        r_target <= n_target;
        r_h <= n_h;
        r_out <= n_out;
    end

    always_comb begin
        n_state = r_state;
        n_ptr = r_ptr;
        n_head = r_head;
        n_prev = r_prev;
        n_nx = r_nx;
        n_need = r_need;
        n_target = r_target;
        n_break = r_break;
        n_h = r_h;
        n_has_prev = r_has_prev;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out = r_out;
        we = 1'b0;
        waddr = r_ptr;
        wdata = 32'd0;
        h_merged = 32'd0;
        case (r_state)
            S_INIT: begin
                we = 1'b1;
                waddr = '0;
                wdata = 32'd1 << B_END;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in.valid && i_in.ready) begin
                    n_ptr = '0;
                    n_has_prev = 1'b0;
                    if (i_in.data.func == FUNC_ALLOC) begin
                        n_need = (i_in.data.request_bytes == 16'd0) ? AB : round;
                        n_state = S_A_RD;
                    end else if (OW'(i_in.data.block_addr) < HB) begin
                        n_out_valid = 1'b1;
                        n_out = '{payload_addr: 16'd0, status: ST_BAD_FREE,
                                  break_offset: 16'd0};
                        n_out.break_offset = (r_break > OW'(16'hFFFF)) ? 16'hFFFF
                                                                        : r_break[15:0];
                    end else begin
                        n_target = OW'(i_in.data.block_addr) - HB;
                        n_state = S_F_RD;
                    end
                end
            end
            S_A_RD: n_state = S_A_CHK;
            S_A_CHK: begin
                n_head = r_ptr;
                if (rdata[B_END]) begin
                    if (r_ptr + HB + HB + r_need > HEAP) begin
                        n_out = '{payload_addr: 16'd0, status: ST_OOM, break_offset: 16'd0};
                        n_out.break_offset = (r_break > OW'(16'hFFFF)) ? 16'hFFFF
                                                                        : r_break[15:0];
                        n_out_valid = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        we = 1'b1;
                        wdata = (rdata & (32'd1 << B_PFREE)) | 32'(r_need);
                        n_nx = r_ptr + HB + r_need;
                        n_state = S_A_END2;
                    end
                end else if (rdata[B_FREE] && size >= r_need) begin
                    we = 1'b1;
                    if (size - r_need >= HB + HB) begin
                        wdata = (rdata & (32'd1 << B_PFREE)) | 32'(r_need);
                        n_nx = r_ptr + HB + r_need;
                        n_h = (32'd1 << B_FREE) | 32'(size - r_need - HB);
                        n_state = S_A_SP2;
                    end else begin
                        wdata = rdata & ~(32'd1 << B_FREE);
                        n_ptr = r_ptr + HB + size;
                        n_state = S_A_NXRD;
                    end
                end else begin
                    n_ptr = r_ptr + HB + size;
                    n_state = S_A_RD;
                end
            end
            S_A_END2: begin
                we = 1'b1;
                waddr = r_nx;
                wdata = 32'd1 << B_END;
                n_break = r_nx + HB;
                n_out = '{payload_addr: 16'(r_head + HB), status: ST_OK, break_offset: 16'd0};
                n_out.break_offset = (r_nx + HB > OW'(16'hFFFF)) ? 16'hFFFF
                                                                 : 16'(r_nx + HB);
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_A_SP2: begin
                we = 1'b1;
                waddr = r_nx;
                wdata = r_h;
                n_state = S_A_SP3;
            end
            S_A_SP3, S_A_NXWR: begin
                we = 1'b1;
                if (r_state == S_A_SP3) begin
                    waddr = r_nx + hsize;
                    wdata = r_h;
                end else begin
                    waddr = r_ptr;
                    wdata = rdata & ~(32'd1 << B_PFREE);
                end
                n_out = '{payload_addr: 16'(r_head + HB), status: ST_OK, break_offset: 16'd0};
                n_out.break_offset = (r_break > OW'(16'hFFFF)) ? 16'hFFFF : r_break[15:0];
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_A_NXRD: n_state = S_A_NXWR;
            S_F_RD: n_state = S_F_CHK;
            S_F_CHK: begin
                if (rdata[B_END] || (r_ptr == r_target && rdata[B_FREE])) begin
                    n_out = '{payload_addr: 16'd0, status: ST_BAD_FREE, break_offset: 16'd0};
                    n_out.break_offset = (r_break > OW'(16'hFFFF)) ? 16'hFFFF
                                                                    : r_break[15:0];
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end else if (r_ptr == r_target) begin
                    n_h = rdata | (32'd1 << B_FREE);
                    n_ptr = r_ptr + HB + size;
                    n_state = S_F_NXRD;
                end else begin
                    n_prev = r_ptr;
                    n_has_prev = 1'b1;
                    n_ptr = r_ptr + HB + size;
                    n_state = S_F_RD;
                end
            end
            S_F_NXRD: n_state = S_F_NXCHK;
            S_F_NXCHK: begin
                we = 1'b1;
                wdata = rdata | (32'd1 << B_PFREE);
                if (!rdata[B_END] && rdata[B_FREE]) begin
                    h_merged = 32'(hsize + size + HB);
                    n_h = {r_h[31:SZ_BITS], h_merged[SZ_BITS-1:0]};
                end
                n_state = S_F_WT;
            end
            S_F_WT: begin
                we = 1'b1;
                waddr = r_target;
                wdata = r_h;
                if (r_h[B_PFREE] && r_has_prev) begin
                    n_ptr = r_prev;
                    n_state = S_F_PRD;
                end else begin
                    n_head = r_target;
                    n_state = S_F_TAG;
                end
            end
            S_F_PRD: n_state = S_F_PCHK;
            S_F_PCHK: begin
                h_merged = 32'(size + hsize + HB);
                n_h = {rdata[31:SZ_BITS], h_merged[SZ_BITS-1:0]};
                we = 1'b1;
                wdata = n_h;
                n_head = r_prev;
                n_state = S_F_TAG;
            end
            S_F_TAG: begin
                we = 1'b1;
                waddr = r_head + hsize;
                wdata = r_h;
                n_ptr = r_head + HB + hsize;
                n_state = S_F_ERD;
            end
            S_F_ERD: n_state = S_F_ECHK;
            S_F_ECHK: begin
                n_out = '{payload_addr: 16'd0, status: ST_OK, break_offset: 16'd0};
                n_out.break_offset = (r_break > OW'(16'hFFFF)) ? 16'hFFFF : r_break[15:0];
                if (rdata[B_END]) begin
                    we = 1'b1;
                    waddr = r_head;
                    wdata = 32'd1 << B_END;
                    n_break = r_head + HB;
                    n_out.break_offset = (r_head + HB > OW'(16'hFFFF)) ? 16'hFFFF
                                                                       : 16'(r_head + HB);
                end
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import ffha_pkg::*;

    localparam int unsigned HEAP = 65536;
    localparam int unsigned HDR = 8;
    localparam int unsigned ALN = 8;
    localparam int unsigned WALK_MAX = HEAP / HDR + 2;
    localparam logic [31:0] SZ_M = (32'd1 << SZ_BITS) - 1;
    localparam logic [31:0] M_FREE = 32'd1 << B_FREE;
    localparam logic [31:0] M_PFREE = 32'd1 << B_PFREE;
    localparam logic [31:0] M_END = 32'd1 << B_END;
    localparam int RANDOM_ITEMS = 1500;
    localparam int CALM_TAIL = 200;
    localparam int STALL_LIMIT = 200000;

    logic i_clk;
    logic i_rst_n;
    ffha_in_if in_ch ();
    ffha_out_if out_ch ();

    first_fit_heap_allocator_top u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_ch),
        .o_out(out_ch)
    );

    logic [31:0] heap_mem [int unsigned];
    int unsigned brk;
    int unsigned live_blocks [$];

    t_in_beat pending_beats [$];
    t_out_beat pending_results [$];
    t_out_beat awaited_results [$];
    int total_items;
    int accepted_items;
    int received_items;
    int mismatches;
    int in_gap;
    int out_gap;
    int quiet_cycles;

    function automatic logic [31:0] hrd(int unsigned off);
        if (off < HEAP && heap_mem.exists(off)) return heap_mem[off];
        return 32'd0;
    endfunction

    function automatic void hwr(int unsigned off, logic [31:0] v);
        if (off < HEAP) heap_mem[off] = v;
    endfunction

    function automatic int unsigned next_blk(int unsigned off);
        return off + HDR + (hrd(off) & SZ_M);
    endfunction

    function automatic t_out_beat make_result(int unsigned pay, logic [1:0] st);
        t_out_beat r;
        r.payload_addr = pay[15:0];
        r.status = st;
        r.break_offset = brk > 65535 ? 16'hFFFF : brk[15:0];
        return r;
    endfunction

    function automatic t_out_beat predict_alloc(int unsigned req);
        int unsigned need, head, old, n, nx, e;
        logic [31:0] h, nv;
        need = req == 0 ? ALN : ((req + ALN - 1) / ALN) * ALN;
        head = 0;
        for (int unsigned i = 0; i < WALK_MAX && head < HEAP; i++) begin
            h = hrd(head);
            if (h & M_END) begin
                if (head + 2 * HDR + need > HEAP) return make_result(0, ST_OOM);
                hwr(head, (h & M_PFREE) | need);
                e = head + HDR + need;
                hwr(e, M_END);
                brk = e + HDR;
                return make_result(head + HDR, ST_OK);
            end
            if ((h & M_FREE) && (h & SZ_M) >= need) begin
                old = h & SZ_M;
                if (old - need >= 2 * HDR) begin
                    n = head + HDR + need;
                    nv = M_FREE | (old - need - HDR);
                    hwr(head, (h & M_PFREE) | need);
                    hwr(n, nv);
                    hwr(n + (nv & SZ_M), nv);
                end else begin
                    hwr(head, h & ~M_FREE);
                end
                nx = next_blk(head);
                hwr(nx, hrd(nx) & ~M_PFREE);
                return make_result(head + HDR, ST_OK);
            end
            head = next_blk(head);
        end
        return make_result(0, ST_OOM);
    endfunction

    function automatic t_out_beat predict_free(int unsigned addr);
        int unsigned target, cur, prv, nx;
        logic [31:0] h, hv, nv, pv;
        bit found, has_prev;
        cur = 0;
        prv = 0;
        h = 0;
        found = 0;
        has_prev = 0;
        if (addr < HDR) return make_result(0, ST_BAD_FREE);
        target = addr - HDR;
        for (int unsigned i = 0; i < WALK_MAX && cur < HEAP; i++) begin
            h = hrd(cur);
            if (h & M_END) break;
            if (cur == target) begin
                found = 1;
                break;
            end
            prv = cur;
            has_prev = 1;
            cur = next_blk(cur);
        end
        if (!found || (h & M_FREE)) return make_result(0, ST_BAD_FREE);
        hv = h | M_FREE;
        nx = next_blk(target);
        nv = hrd(nx) | M_PFREE;
        hwr(nx, nv);
        if (!(nv & M_END) && (nv & M_FREE))
            hv = (hv & ~SZ_M) | (((hv & SZ_M) + (nv & SZ_M) + HDR) & SZ_M);
        hwr(target, hv);
        cur = target;
        if ((hv & M_PFREE) && has_prev) begin
            pv = hrd(prv);
            pv = (pv & ~SZ_M) | (((pv & SZ_M) + (hv & SZ_M) + HDR) & SZ_M);
            hwr(prv, pv);
            cur = prv;
            hv = pv;
        end
        hwr(cur + (hv & SZ_M), hv);
        nx = next_blk(cur);
        if (hrd(nx) & M_END) begin
            hwr(cur, M_END);
            brk = cur + HDR;
        end
        return make_result(0, ST_OK);
    endfunction

    task automatic queue_op(logic func, logic [15:0] req, logic [15:0] addr);
        t_in_beat b;
        t_out_beat r;
        int idx [$];
        b.func = func;
        b.request_bytes = req;
        b.block_addr = addr;
        if (func == FUNC_ALLOC) begin
            r = predict_alloc(req);
            if (r.status == ST_OK) live_blocks.push_back(r.payload_addr);
        end else begin
            r = predict_free(addr);
            if (r.status == ST_OK) begin
                idx = live_blocks.find_first_index(x) with (x == addr);
                if (idx.size() > 0) live_blocks.delete(idx[0]);
            end
        end
        pending_beats.push_back(b);
        pending_results.push_back(r);
        total_items++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_gap <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                void'(pending_beats.pop_front());
                awaited_results.push_back(pending_results.pop_front());
                accepted_items++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (in_gap > 0) begin
                    in_ch.valid <= 1'b0;
                    in_gap <= in_gap - 1;
                end else if (accepted_items < total_items - CALM_TAIL
                             && $urandom_range(0, 7) == 0) begin
                    in_ch.valid <= 1'b0;
                    in_gap <= $urandom_range(0, 10);
                end else if (pending_beats.size() > 0) begin
                    in_ch.valid <= 1'b1;
                    in_ch.data <= pending_beats[0];
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_gap <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                received_items++;
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %p", out_ch.data);
                end else begin
                    if (out_ch.data !== awaited_results[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("beat %0d: expected addr %h st %0d brk %h, got addr %h st %0d brk %h",
                                received_items, awaited_results[0].payload_addr,
                                awaited_results[0].status, awaited_results[0].break_offset,
                                out_ch.data.payload_addr, out_ch.data.status,
                                out_ch.data.break_offset);
                    end
                    void'(awaited_results.pop_front());
                end
            end
            if (out_gap > 0) begin
                out_ch.ready <= 1'b0;
                out_gap <= out_gap - 1;
            end else if (received_items < total_items - CALM_TAIL
                         && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                out_gap <= $urandom_range(0, 10);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned a0, a1, a2, a3, pick;
        int idx;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        total_items = 0;
        accepted_items = 0;
        received_items = 0;
        mismatches = 0;
        quiet_cycles = 0;
        heap_mem[0] = M_END;
        brk = HDR;

        queue_op(FUNC_FREE, 16'h0000, 16'h0008);
        queue_op(FUNC_FREE, 16'hFFFF, 16'h0000);
        queue_op(FUNC_ALLOC, 16'h0000, 16'hFFFF);
        queue_op(FUNC_ALLOC, 16'h0001, 16'h0000);
        queue_op(FUNC_ALLOC, 16'hFFFF, 16'h0000);
        queue_op(FUNC_ALLOC, 16'hFFE8, 16'h0000);
        queue_op(FUNC_ALLOC, 16'd40, 16'h0000);
        queue_op(FUNC_ALLOC, 16'd17, 16'h0000);
        a0 = 8; a1 = 24; a2 = 40; a3 = 88;
        queue_op(FUNC_FREE, 16'h0000, 16'd44);
        queue_op(FUNC_FREE, 16'h0000, a1[15:0]);
        queue_op(FUNC_FREE, 16'h0000, a1[15:0]);
        queue_op(FUNC_FREE, 16'h0000, a0[15:0]);
        queue_op(FUNC_ALLOC, 16'd8, 16'h0000);
        queue_op(FUNC_ALLOC, 16'd16, 16'h0000);
        queue_op(FUNC_FREE, 16'h0000, a3[15:0]);
        queue_op(FUNC_FREE, 16'h0000, 16'hFFFF);
        queue_op(FUNC_FREE, 16'h0000, 16'h0007);
        while (live_blocks.size() > 0) queue_op(FUNC_FREE, 16'h0000, live_blocks[0][15:0]);
        queue_op(FUNC_ALLOC, 16'hFFF0, 16'h0000);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50 && (live_blocks.size() < 60 || pick < 10)) begin
                if ($urandom_range(0, 19) == 0)
                    queue_op(FUNC_ALLOC, 16'($urandom), 16'($urandom));
                else
                    queue_op(FUNC_ALLOC, 16'($urandom_range(0, 300)), 16'($urandom));
            end else if (pick < 88 && live_blocks.size() > 0) begin
                idx = $urandom_range(0, live_blocks.size() - 1);
                queue_op(FUNC_FREE, 16'($urandom), live_blocks[idx][15:0]);
            end else if (pick < 94) begin
                queue_op(FUNC_FREE, 16'($urandom), 16'($urandom));
            end else begin
                queue_op(FUNC_FREE, 16'($urandom), 16'($urandom_range(0, 600)));
            end
        end

        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_beats.size() == 0 && awaited_results.size() == 0);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
